// ===== rtl/plnm_pkg.sv =====
package plnm_pkg;

    localparam int NUM_EDGES      = 64;
    localparam int NUM_PATH_NODES = 32;
    localparam int TABLE_DEPTH    = NUM_EDGES * NUM_PATH_NODES;
    localparam int ADDR_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EDGE_CW        = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;
    localparam int NODE_CW        = $clog2(NUM_PATH_NODES);

    localparam int NODE_W   = 64;
    localparam int EDGE_FW  = 6;
    localparam int NODEP_FW = 5;
    localparam int THR_W    = 30;
    localparam int LIMIT_W  = 32;
    localparam int DSQ_W    = 33;
    localparam int DOT_W    = 33;

    localparam logic [THR_W-1:0]   HEADING_THR_RESET = 30'd187904819;
    localparam logic [LIMIT_W-1:0] MAX_DIST_SQ_RESET = 32'd1509949;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [2:0] REG_HEADING_THR = 3'd0;
    localparam logic [2:0] REG_MAX_DIST_SQ = 3'd4;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] cosv;
        logic signed [15:0] sinv;
    } t_pose;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [EDGE_CW-1:0] edge_idx;
        logic [NODE_CW-1:0] node_idx;
    } t_tag;

endpackage

// ===== rtl/pose_to_lane_node_matcher.sv =====
// Channel    Handshake                  Payload
// input      i_in_valid / o_in_stall    i_action, i_node_edge, i_node_position,
//                                       i_pos_x, i_pos_y, i_dir_cos, i_dir_sin
// output     o_out_valid / i_out_stall  o_node_hit, o_matched_edge, o_matched_node
// config     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// A load writes one table entry through the RAM write port. A query scan reads
// one node per cycle from the single RAM read port, then the evaluation pipe drains.
// o_in_stall stays high during a query; the result sits in an output register,
// so a stalled result blocks only the end of the next query.
// Reset restores the register defaults; the node table is not cleared.
module pose_to_lane_node_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic [plnm_pkg::EDGE_FW-1:0]        i_node_edge,
    input  logic [plnm_pkg::NODEP_FW-1:0]       i_node_position,
    input  logic signed [15:0]                  i_pos_x,
    input  logic signed [15:0]                  i_pos_y,
    input  logic signed [15:0]                  i_dir_cos,
    input  logic signed [15:0]                  i_dir_sin,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_node_hit,
    output logic [plnm_pkg::EDGE_FW-1:0]        o_matched_edge,
    output logic [plnm_pkg::NODEP_FW-1:0]       o_matched_node,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import plnm_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state, n_state;
    logic [THR_W-1:0]   r_thr;
    logic [LIMIT_W-1:0] r_limit;
    t_pose r_pose;
    logic [ADDR_W-1:0]  r_addr;
    logic [EDGE_CW-1:0] r_edge;
    logic [NODE_CW-1:0] r_node;
    t_tag r_s1_tag;
    logic r_found;
    logic [DSQ_W-1:0]   r_best;
    logic [EDGE_CW-1:0] r_best_edge;
    logic [NODE_CW-1:0] r_best_node;
    logic r_out_valid;
    logic r_out_found;
    logic [EDGE_FW-1:0]  r_out_edge;
    logic [NODEP_FW-1:0] r_out_node;

    logic in_acc, cfg_wr, load_we, in_range, scan_last, out_free;
    logic [ADDR_W-1:0] load_addr;
    logic [NODE_W-1:0] load_word, rd_word;
    logic [31:0] best_edge_x, best_node_x;
    t_tag s0_tag, ev_tag;
    logic [DSQ_W-1:0] ev_d2;
    logic ev_pass;

    always_comb begin
        in_acc    = i_in_valid && !o_in_stall;
        cfg_wr    = psel && penable && pwrite;
        in_range  = (32'(i_node_edge) < NUM_EDGES) && (32'(i_node_position) < NUM_PATH_NODES);
        load_we   = in_acc && (i_action == ACT_LOAD) && in_range;
        load_addr = ADDR_W'(ADDR_W'(i_node_edge) * ADDR_W'(NUM_PATH_NODES)
                    + ADDR_W'(i_node_position));
        load_word = {i_dir_sin, i_dir_cos, i_pos_y, i_pos_x};
        scan_last = (r_edge == EDGE_CW'(NUM_EDGES - 1))
                    && (r_node == NODE_CW'(NUM_PATH_NODES - 1));
        s0_tag.valid    = (r_state == ST_SCAN);
        s0_tag.last     = scan_last;
        s0_tag.edge_idx = r_edge;
        s0_tag.node_idx = r_node;
        out_free    = !r_out_valid || !i_out_stall;
        best_edge_x = 32'(r_best_edge);
        best_node_x = 32'(r_best_node);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_action == ACT_QUERY)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (ev_tag.valid && ev_tag.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    plnm_ram #(
        .WIDTH(NODE_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_addr),
        .i_wdata (load_word),
        .i_raddr (r_addr),
        .o_rdata (rd_word)
    );

    plnm_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s1_tag),
        .i_node  (rd_word),
        .i_pose  (r_pose),
        .i_thr   (r_thr),
        .i_limit (r_limit),
        .o_tag   (ev_tag),
        .o_d2    (ev_d2),
        .o_pass  (ev_pass)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= HEADING_THR_RESET;
            r_limit     <= MAX_DIST_SQ_RESET;
            r_s1_tag    <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_addr      <= '0;
            r_edge      <= '0;
            r_node      <= '0;
        end else begin
            r_state  <= n_state;
            r_s1_tag <= s0_tag;
            if (cfg_wr && (paddr == REG_HEADING_THR)) begin
                r_thr <= pwdata[THR_W-1:0];
            end
            if (cfg_wr && (paddr == REG_MAX_DIST_SQ)) begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end
            if (r_state == ST_IDLE) begin
                r_addr  <= '0;
                r_edge  <= '0;
                r_node  <= '0;
                r_found <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_addr <= r_addr + ADDR_W'(1);
                if (r_node == NODE_CW'(NUM_PATH_NODES - 1)) begin
                    r_node <= '0;
                    r_edge <= r_edge + EDGE_CW'(1);
                end else begin
                    r_node <= r_node + NODE_CW'(1);
                end
            end
            if (ev_tag.valid && ev_pass && (!r_found || (ev_d2 < r_best))) begin
                r_found <= 1'b1;
            end
            if ((r_state == ST_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_action == ACT_QUERY)) begin
            r_pose      <= '{x: i_pos_x, y: i_pos_y, cosv: i_dir_cos, sinv: i_dir_sin};
            r_best_edge <= '0;
            r_best_node <= '0;
        end else if (ev_tag.valid && ev_pass && (!r_found || (ev_d2 < r_best))) begin
            r_best      <= ev_d2;
            r_best_edge <= ev_tag.edge_idx;
            r_best_node <= ev_tag.node_idx;
        end
        if ((r_state == ST_FINISH) && out_free) begin
            r_out_found <= r_found;
            r_out_edge  <= best_edge_x[EDGE_FW-1:0];
            r_out_node  <= best_node_x[NODEP_FW-1:0];
        end
    end

    always_comb begin
        case (paddr)
            REG_HEADING_THR: prdata = {{(32-THR_W){1'b0}}, r_thr};
            REG_MAX_DIST_SQ: prdata = r_limit;
            default:         prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_node_hit     = r_out_found;
    assign o_matched_edge = r_out_edge;
    assign o_matched_node = r_out_node;

endmodule

// ===== rtl/plnm_ram.sv =====
module plnm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/plnm_eval.sv =====
module plnm_eval (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  plnm_pkg::t_tag                      i_tag,
    input  logic [plnm_pkg::NODE_W-1:0]         i_node,
    input  plnm_pkg::t_pose                     i_pose,
    input  logic [plnm_pkg::THR_W-1:0]          i_thr,
    input  logic [plnm_pkg::LIMIT_W-1:0]        i_limit,
    output plnm_pkg::t_tag                      o_tag,
    output logic [plnm_pkg::DSQ_W-1:0]          o_d2,
    output logic                                o_pass
);
    import plnm_pkg::*;

    logic signed [15:0] nx, ny, nc, ns;
    logic signed [16:0] dx_a, dy_a;
    logic signed [31:0] pc_a, ps_a;
    logic signed [33:0] sqx_b, sqy_b;
    logic signed [DOT_W-1:0] dot_b;
    logic [DSQ_W-1:0] d2_c;
    logic signed [DOT_W-1:0] thr_ext;

    t_tag r_tag_a, r_tag_b, r_tag_c;
    logic signed [16:0] r_dx, r_dy;
    logic signed [31:0] r_pc, r_ps;
    logic [31:0] r_dx2, r_dy2;
    logic signed [DOT_W-1:0] r_dot;
    logic [DSQ_W-1:0] r_d2;
    logic r_pass;

    always_comb begin
        nx      = $signed(i_node[15:0]);
        ny      = $signed(i_node[31:16]);
        nc      = $signed(i_node[47:32]);
        ns      = $signed(i_node[63:48]);
        dx_a    = {nx[15], nx} - {i_pose.x[15], i_pose.x};
        dy_a    = {ny[15], ny} - {i_pose.y[15], i_pose.y};
        pc_a    = nc * i_pose.cosv;
        ps_a    = ns * i_pose.sinv;
        sqx_b   = r_dx * r_dx;
        sqy_b   = r_dy * r_dy;
        dot_b   = {r_pc[31], r_pc} + {r_ps[31], r_ps};
        d2_c    = {1'b0, r_dx2} + {1'b0, r_dy2};
        thr_ext = {{(DOT_W-THR_W){i_thr[THR_W-1]}}, i_thr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_tag_c <= '0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
            r_tag_c <= r_tag_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= dx_a;
        r_dy   <= dy_a;
        r_pc   <= pc_a;
        r_ps   <= ps_a;
        r_dx2  <= sqx_b[31:0];
        r_dy2  <= sqy_b[31:0];
        r_dot  <= dot_b;
        r_d2   <= d2_c;
        r_pass <= (r_dot > thr_ext) && (d2_c < {1'b0, i_limit});
    end

    assign o_tag  = r_tag_c;
    assign o_d2   = r_d2;
    assign o_pass = r_pass;

endmodule

// ===== verif/plnm_checker.sv =====
`timescale 1ns / 100ps

module plnm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [plnm_pkg::EDGE_FW-1:0]      i_node_edge,
    input  logic [plnm_pkg::NODEP_FW-1:0]     i_node_position,
    input  logic signed [15:0]                i_pos_x,
    input  logic signed [15:0]                i_pos_y,
    input  logic signed [15:0]                i_dir_cos,
    input  logic signed [15:0]                i_dir_sin,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic                              o_node_hit,
    input  logic [plnm_pkg::EDGE_FW-1:0]      o_matched_edge,
    input  logic [plnm_pkg::NODEP_FW-1:0]     o_matched_node,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    input  logic                              pready,
    output int unsigned                       o_fail_count,
    output int unsigned                       o_open_count
);
    import plnm_pkg::*;

    typedef struct packed {
        logic                found;
        logic [EDGE_FW-1:0]  edge_idx;
        logic [NODEP_FW-1:0] node_idx;
    } t_match;

    t_pose                   lane_nodes [TABLE_DEPTH];
    logic signed [THR_W-1:0] heading_floor;
    logic [LIMIT_W-1:0]      dist_ceiling;
    t_match                  awaited_matches [$];

    function automatic t_match nearest_lane_node(input t_pose q);
        t_match best;
        t_pose  cand;
        longint dot, dx, dy, d2, best_d2;
        best = '0;
        best_d2 = 0;
        for (int e = 0; e < NUM_EDGES; e++) begin
            for (int n = 0; n < NUM_PATH_NODES; n++) begin
                cand = lane_nodes[e * NUM_PATH_NODES + n];
                dot = longint'(cand.cosv) * longint'(q.cosv)
                    + longint'(cand.sinv) * longint'(q.sinv);
                dx = longint'(cand.x) - longint'(q.x);
                dy = longint'(cand.y) - longint'(q.y);
                d2 = dx * dx + dy * dy;
                if (dot > longint'(heading_floor) && d2 < longint'(dist_ceiling)
                        && (!best.found || d2 < best_d2)) begin
                    best.found = 1'b1;
                    best.edge_idx = EDGE_FW'(e);
                    best.node_idx = NODEP_FW'(n);
                    best_d2 = d2;
                end
            end
        end
        return best;
    endfunction

    task automatic report_miss(input string what);
        $display("[%0t] %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_match want;
        t_pose  beat;
        if (!i_rst_n) begin
            heading_floor = HEADING_THR_RESET;
            dist_ceiling = MAX_DIST_SQ_RESET;
            awaited_matches.delete();
            foreach (lane_nodes[i]) lane_nodes[i] = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    REG_HEADING_THR: heading_floor = pwdata[THR_W-1:0];
                    REG_MAX_DIST_SQ: dist_ceiling = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (awaited_matches.size() == 0) begin
                    report_miss("result beat with no query outstanding");
                end else begin
                    want = awaited_matches.pop_front();
                    if (o_node_hit !== want.found)
                        report_miss($sformatf("node hit %b, predicted %b",
                                              o_node_hit, want.found));
                    if (o_matched_edge !== want.edge_idx)
                        report_miss($sformatf("matched_edge %0d, predicted %0d",
                                              o_matched_edge, want.edge_idx));
                    if (o_matched_node !== want.node_idx)
                        report_miss($sformatf("matched_node %0d, predicted %0d",
                                              o_matched_node, want.node_idx));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                beat = {i_pos_x, i_pos_y, i_dir_cos, i_dir_sin};
                if (i_action == ACT_LOAD) begin
                    if (i_node_edge < NUM_EDGES && i_node_position < NUM_PATH_NODES)
                        lane_nodes[i_node_edge * NUM_PATH_NODES + i_node_position] = beat;
                end else begin
                    awaited_matches = {awaited_matches, nearest_lane_node(beat)};
                end
            end
        end
        o_open_count <= awaited_matches.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import plnm_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_CYCLES = 5000;
    localparam int SPOT_X      = -30000;
    localparam int SPOT_Y      = 30000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_action;
    logic [EDGE_FW-1:0]    i_node_edge;
    logic [NODEP_FW-1:0]   i_node_position;
    logic signed [15:0]    i_pos_x;
    logic signed [15:0]    i_pos_y;
    logic signed [15:0]    i_dir_cos;
    logic signed [15:0]    i_dir_sin;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_node_hit;
    logic [EDGE_FW-1:0]    o_matched_edge;
    logic [NODEP_FW-1:0]   o_matched_node;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int unsigned fail_total;
    int unsigned open_count;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;
    t_pose       layout [TABLE_DEPTH];

    pose_to_lane_node_matcher uut (.*);

    plnm_checker chk (
        .*,
        .o_fail_count (fail_total),
        .o_open_count (open_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("pose_to_lane_node_matcher: mismatch");
            $finish;
        end
    end

    function automatic int rand_span(input int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    function automatic int clamp_q14(input int v);
        return (v > 16384) ? 16384 : ((v < -16384) ? -16384 : v);
    endfunction

    function automatic t_pose make_pose(input int x, input int y, input int c, input int s);
        t_pose p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.cosv = 16'(clamp_q14(c));
        p.sinv = 16'(clamp_q14(s));
        return p;
    endfunction

    function automatic t_pose drift(input t_pose base, input int reach, input int twist);
        return make_pose(base.x + rand_span(reach), base.y + rand_span(reach),
                         base.cosv + rand_span(twist), base.sinv + rand_span(twist));
    endfunction

    function automatic t_pose wild_pose();
        return make_pose($urandom, $urandom, rand_span(16384), rand_span(16384));
    endfunction

    function automatic void pick_heading(output int c, output int s);
        c = int'($urandom_range(32768)) - 16384;
        s = $rtoi($sqrt(268435456.0 - real'(c) * real'(c)));
        if ($urandom_range(1))
            s = -s;
    endfunction

    task automatic push_beat(input logic act, input logic [EDGE_FW-1:0] ed,
                             input logic [NODEP_FW-1:0] np, input t_pose p);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(12);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_node_edge     <= ed;
        i_node_position <= np;
        i_pos_x         <= p.x;
        i_pos_y         <= p.y;
        i_dir_cos       <= p.cosv;
        i_dir_sin       <= p.sinv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic load_node(input int e, input int n, input t_pose p);
        layout[e * NUM_PATH_NODES + n] = p;
        push_beat(ACT_LOAD, EDGE_FW'(e), NODEP_FW'(n), p);
    endtask

    task automatic ask_pose(input t_pose p);
        push_beat(ACT_QUERY, EDGE_FW'($urandom), NODEP_FW'($urandom), p);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (open_count != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic retune(input int thr, input logic [31:0] limit);
        settle();
        write_reg(REG_HEADING_THR, 32'(thr));
        write_reg(REG_MAX_DIST_SQ, limit);
    endtask

    // lay each edge out as a straight path so neighbors compete
    task automatic fill_table();
        int bx, by, c, s, sp;
        for (int e = 0; e < NUM_EDGES; e++) begin
            steady = (e < NUM_EDGES / 4);
            bx = int'($urandom_range(65535)) - 32768;
            by = int'($urandom_range(65535)) - 32768;
            pick_heading(c, s);
            sp = $urandom_range(600, 150);
            for (int n = 0; n < NUM_PATH_NODES; n++)
                load_node(e, n, make_pose(bx + n * sp * c / 16384, by + n * sp * s / 16384,
                                          c + rand_span(200), s + rand_span(200)));
        end
        steady = 1'b0;
    endtask

    task automatic directed_probes();
        t_pose spot;
        spot = make_pose(SPOT_X, SPOT_Y, 16384, 0);
        load_node(7, 9, spot);
        load_node(50, 2, spot);
        load_node(0, 0, make_pose(32767, 32767, 16384, 16384));
        load_node(63, 31, make_pose(-32768, -32768, -16384, -16384));
        ask_pose(spot);
        ask_pose(make_pose(SPOT_X + 1228, SPOT_Y, 16384, 0));
        ask_pose(make_pose(SPOT_X + 1229, SPOT_Y, 16384, 0));
        ask_pose(make_pose(32767, 32767, 16384, 16384));
        ask_pose(make_pose(-32768, -32768, -16384, -16384));
        ask_pose(make_pose(0, 0, 0, 0));
        ask_pose(make_pose(32767, -32768, -16384, 16384));
    endtask

    task automatic random_run(input int count);
        int    e, n, pick;
        t_pose base;
        repeat (count) begin
            e = $urandom_range(NUM_EDGES - 1);
            n = $urandom_range(NUM_PATH_NODES - 1);
            base = layout[e * NUM_PATH_NODES + n];
            pick = $urandom_range(99);
            if (pick < 45)
                ask_pose(drift(base, 1400, 2500));
            else if (pick < 55)
                ask_pose(wild_pose());
            else if (pick < 90)
                load_node(e, n, drift(base, 300, 600));
            else
                load_node(e, n, wild_pose());
        end
    endtask

    // hold the result side while queries keep coming, so the input backs up
    task automatic squeeze_output();
        settle();
        hold_req = 1'b1;
        steady = 1'b1;
        repeat (5) ask_pose(drift(layout[$urandom_range(TABLE_DEPTH - 1)], 1000, 2000));
        steady = 1'b0;
    endtask

    initial begin : result_sink
        int unsigned pause;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            pause = steady ? 0 : $urandom_range(12);
            if (pause != 0) begin
                i_out_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall)) begin
                if (hold_req) begin
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_req = 1'b0;
                    i_out_stall <= 1'b0;
                end
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_LOAD;
        i_node_edge     <= '0;
        i_node_position <= '0;
        i_pos_x         <= '0;
        i_pos_y         <= '0;
        i_dir_cos       <= '0;
        i_dir_sin       <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fill_table();
        directed_probes();

        retune(268435456, 32'hFFFF_FFFF);
        load_node(0, 0, make_pose(32767, 32767, 16384, 16384));
        ask_pose(make_pose(32767, 32767, 16384, 0));
        ask_pose(make_pose(32767, 32767, 16384, 1));
        ask_pose(make_pose(-32768, -32768, 16384, 16384));
        random_run(58);

        retune(-268435456, 32'd1507984);
        load_node(7, 9, make_pose(SPOT_X, SPOT_Y, 16384, 0));
        ask_pose(make_pose(SPOT_X + 1228, SPOT_Y, 16384, 0));
        ask_pose(make_pose(SPOT_X + 1227, SPOT_Y, 16384, 0));
        random_run(58);

        retune(0, 32'd0);
        steady = 1'b1;
        random_run(58);
        steady = 1'b0;

        retune(rand_span(268435456), $urandom_range(32'h0400_0000));
        random_run(58);

        retune(int'(HEADING_THR_RESET), MAX_DIST_SQ_RESET);
        random_run(58);
        squeeze_output();

        settle();
        repeat (56) @(posedge i_clk);
        if (fail_total == 0)
            $display("pose_to_lane_node_matcher: match");
        else
            $display("pose_to_lane_node_matcher: mismatch");
        $finish;
    end

endmodule
